// File: rtl/dequ_pkg.sv
package dequ_pkg;

  // Ring geometry
  localparam int Depth = 16;
  localparam int IdxW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 32;

  localparam logic [CntW:0] DepthExt = (CntW + 1)'(Depth);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  // Operation codes
  localparam logic [2:0] OpPushBack = 3'd0;
  localparam logic [2:0] OpPopBack  = 3'd1;
  localparam logic [2:0] OpPopFront = 3'd2;
  localparam logic [2:0] OpClear    = 3'd3;

  // Status codes
  typedef enum logic [1:0] {
    StatOk        = 2'd0,
    StatUnderflow = 2'd1,
    StatOverflow  = 2'd2
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    SIdle = 4'b0001,
    SExec = 4'b0010,
    SLook = 4'b0100,
    SResp = 4'b1000
  } state_e;

  // (base + off) modulo Depth, for base < Depth and off <= Depth
  function automatic logic [IdxW-1:0] ring_pos(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] off);
    logic [CntW:0] sum;
    sum = (CntW + 1)'(base) + (CntW + 1)'(off);
    if (sum >= DepthExt) begin
      sum = sum - DepthExt;
    end
    return sum[IdxW-1:0];
  endfunction

  // Position of the newest entry; position of front when the ring is empty
  function automatic logic [IdxW-1:0] back_pos(input logic [IdxW-1:0] base,
                                               input logic [CntW-1:0] cnt);
    logic [CntW-1:0] off;
    off = (cnt == '0) ? '0 : cnt - CntW'(1);
    return ring_pos(base, off);
  endfunction

endpackage

// File: rtl/dequ_ram.sv
module dequ_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/double_ended_queue_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-----------------------------------------------
// command  | start_i / busy_o     | operation_i, push_value_i
// result   | valid_o (one cycle)  | popped_value_o, front_value_o, back_value_o,
//          |                      | entry_count_o, is_empty_o, is_full_o, status_o
//
// Each transaction runs in order: the popped word is read from the ring
// memory, then pointers and count are updated and a push is written, then the
// front and back words are read on the memory's two read ports.
// The result strobe comes in SResp, after the SExec and SLook states; a new command
// may be accepted in the same cycle as the strobe, and not before it.
// Reset clears pointers, count and sequencer; ring contents are not cleared.
// The receiver cannot stall; results are never held.
module double_ended_queue_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [2:0]                  operation_i,
  input  logic signed [31:0]          push_value_i,
  output logic                        valid_o,
  output logic signed [31:0]          popped_value_o,
  output logic signed [31:0]          front_value_o,
  output logic signed [31:0]          back_value_o,
  output logic [4:0]                  entry_count_o,
  output logic                        is_empty_o,
  output logic                        is_full_o,
  output logic [1:0]                  status_o
);

  localparam int IdxW  = dequ_pkg::IdxW;
  localparam int CntW  = dequ_pkg::CntW;
  localparam int DataW = dequ_pkg::DataW;

  dequ_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]   front_q, front_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [2:0]        op_q;
  logic [DataW-1:0]  val_q;
  logic [DataW-1:0]  popped_q, popped_d;
  dequ_pkg::status_e status_q, status_d;

  logic              accept;
  logic              we;
  logic [IdxW-1:0]   waddr;
  logic [IdxW-1:0]   raddr_a, raddr_b;
  logic [DataW-1:0]  rdata_a, rdata_b;
  logic              resp;

  assign resp   = (state_q == dequ_pkg::SResp);
  assign busy_o = !((state_q == dequ_pkg::SIdle) || resp);
  assign accept = start_i && !busy_o;

  // Ring storage
  dequ_ram #(
    .Width (DataW),
    .Depth (dequ_pkg::Depth)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (val_q),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // Read addresses: popped word at acceptance, front/back after update
  always_comb begin
    raddr_b = dequ_pkg::back_pos(front_q, cnt_q);
    if (state_q == dequ_pkg::SLook) begin
      raddr_a = front_q;
    end else if (operation_i == dequ_pkg::OpPopFront) begin
      raddr_a = front_q;
    end else begin
      raddr_a = dequ_pkg::back_pos(front_q, cnt_q);
    end
  end

  // Execute step: pointer and count update, push write
  always_comb begin
    front_d  = front_q;
    cnt_d    = cnt_q;
    popped_d = popped_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = dequ_pkg::ring_pos(front_q, cnt_q);
    if (state_q == dequ_pkg::SExec) begin
      popped_d = '0;
      status_d = dequ_pkg::StatOk;
      case (op_q)
        dequ_pkg::OpPushBack: begin
          if (cnt_q == dequ_pkg::DepthCnt) begin
            status_d = dequ_pkg::StatOverflow;
          end else begin
            we    = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end
        end
        dequ_pkg::OpPopBack: begin
          if (cnt_q == '0) begin
            status_d = dequ_pkg::StatUnderflow;
          end else begin
            popped_d = rdata_a;
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        dequ_pkg::OpPopFront: begin
          if (cnt_q == '0) begin
            status_d = dequ_pkg::StatUnderflow;
          end else begin
            popped_d = rdata_a;
            front_d  = dequ_pkg::ring_pos(front_q, CntW'(1));
            cnt_d    = cnt_q - CntW'(1);
          end
        end
        dequ_pkg::OpClear: begin
          cnt_d   = '0;
          front_d = '0;
        end
        default: begin
          // unused codes behave as a query
        end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      dequ_pkg::SIdle: if (accept) state_d = dequ_pkg::SExec;
      dequ_pkg::SExec: state_d = dequ_pkg::SLook;
      dequ_pkg::SLook: state_d = dequ_pkg::SResp;
      dequ_pkg::SResp: state_d = accept ? dequ_pkg::SExec : dequ_pkg::SIdle;
      default:         state_d = dequ_pkg::SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dequ_pkg::SIdle;
      front_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      front_q <= front_d;
      cnt_q   <= cnt_d;
    end
  end

  // Transaction payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= operation_i;
      val_q <= push_value_i;
    end
    popped_q <= popped_d;
    status_q <= status_d;
  end

  // Result formatting
  always_comb begin
    valid_o        = resp;
    popped_value_o = resp ? popped_q : '0;
    front_value_o  = (resp && cnt_q != '0) ? rdata_a : '0;
    back_value_o   = (resp && cnt_q != '0) ? rdata_b : '0;
    entry_count_o  = resp ? cnt_q : '0;
    is_empty_o     = resp && (cnt_q == '0);
    is_full_o      = resp && (cnt_q == dequ_pkg::DepthCnt);
    status_o       = resp ? status_q : dequ_pkg::StatOk;
  end

endmodule

// File: rtl/dequ_checker.sv
module dequ_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               valid_o,
  input logic signed [31:0] front_value_o,
  input logic signed [31:0] back_value_o,
  input logic [4:0]         entry_count_o,
  input logic               is_empty_o,
  input logic               is_full_o,
  input logic [1:0]         status_o
);

  // Every accepted transaction yields its result strobe
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 valid_o)
    else $error("result missing three cycles after acceptance");

  // A result only shows while the unit is ready for the next command
  a_result_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o)
    else $error("result shown while busy");

  // Flags agree with the count
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (is_empty_o == (entry_count_o == 5'd0)) &&
                (is_full_o == (entry_count_o == 5'd16)) && (entry_count_o <= 5'd16))
    else $error("flags disagree with entry count");

  // Empty ring peeks as zero
  a_empty_peek: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && is_empty_o |-> (front_value_o == 32'sd0) && (back_value_o == 32'sd0))
    else $error("nonzero peek on empty ring");

  // Overflow only on a full ring, underflow only on an empty one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (status_o == 2'd0) || (status_o == 2'd1 && is_empty_o) ||
                (status_o == 2'd2 && is_full_o))
    else $error("status inconsistent with ring state");

endmodule

bind double_ended_queue_unit dequ_checker u_dequ_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start_i       (start_i),
  .busy_o        (busy_o),
  .valid_o       (valid_o),
  .front_value_o (front_value_o),
  .back_value_o  (back_value_o),
  .entry_count_o (entry_count_o),
  .is_empty_o    (is_empty_o),
  .is_full_o     (is_full_o),
  .status_o      (status_o)
);
